@@ src/assert_macros.svh @@
// Assertion macros used by the RTL of the RPN evaluator.
// Every macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ src/rpn_pkg.sv @@
// Package for the RPN stack evaluator: sizes, opcode and status codes,
// controller states, payload structs and the divider request and response.
// It depends on nothing.
package rpn_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int DEPTH_W     = 7;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W       = $clog2(DATA_W);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SP_W-1:0]   sp_t;
  typedef logic [DATA_W-1:0] word_t;

  // Token opcodes; codes above OP_DIV are ignored tokens.
  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_DIVZERO = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } rpn_tok_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
    status_e                  status;
    logic                     done_res;
  } rpn_res_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
  } div_rsp_t;

endpackage

@@ src/rpn_stack_evaluator.sv @@
// RPN stack evaluator: one token in, one result out, stack held in a RAM.
// A token is taken in S_IDLE and worked in S_EXEC; a divide then waits in S_DIV on the
// 32-step divider, and the result is registered, with res_valid, when S_FIN finishes.
// A new token is taken only once the last one is finished; a stalled result holds
// the following token in S_FIN until the result transfer frees the output.
// Reset (synchronous, rst high) empties the stack; stack RAM contents stay undefined.
`include "assert_macros.svh"

module rpn_stack_evaluator (
  input  logic              clk,
  input  logic              rst,
  input  logic              tok_valid,
  output logic              tok_ready,
  input  rpn_pkg::rpn_tok_t tok,
  output logic              res_valid,
  input  logic              res_ready,
  output rpn_pkg::rpn_res_t res
);
  import rpn_pkg::*;

  state_e   state;
  state_e   state_next;
  sp_t      sp;
  sp_t      sp_after;
  word_t    top_reg;
  word_t    top_after;
  rpn_tok_t item;

  // Pending result of the current token.
  word_t    acc_val;
  word_t    acc_val_next;
  status_e  acc_status;
  status_e  acc_status_next;
  logic     acc_wr;
  logic     acc_wr_next;
  logic     acc_push;
  logic     acc_push_next;
  logic     acc_load;

  logic     out_free;
  logic     finish;
  logic     wr_en;
  addr_t    wr_addr;
  addr_t    rd_addr;
  word_t    rd_data;
  word_t    left;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Operand stack storage.
  rpn_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(acc_val),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  rpn_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // The second entry from the top is read every cycle; the top lives in top_reg.
  assign rd_addr  = ADDR_W'(sp - SP_W'(2));
  assign left     = rd_data;
  assign out_free = !res_valid || res_ready;

  // Stack state after the pending result is applied.
  always_comb begin
    sp_after  = sp;
    top_after = (sp != '0) ? top_reg : '0;
    if (acc_wr) begin
      sp_after  = acc_push ? sp + SP_W'(1) : sp - SP_W'(1);
      top_after = acc_val;
    end
  end

  // Next state and control.
  always_comb begin
    state_next       = state;
    tok_ready        = 1'b0;
    acc_load         = 1'b0;
    acc_val_next     = acc_val;
    acc_status_next  = ST_OK;
    acc_wr_next      = 1'b0;
    acc_push_next    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = left;
    div_req.divisor  = top_reg;
    finish           = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = acc_push ? ADDR_W'(sp) : ADDR_W'(sp - SP_W'(2));
    case (state)
      S_IDLE: begin
        tok_ready = 1'b1;
        if (tok_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        acc_load   = 1'b1;
        state_next = S_FIN;
        case (item.opcode)
          OP_PUSH: begin
            if (sp >= SP_W'(STACK_DEPTH)) begin
              acc_status_next = ST_OVER;
            end else begin
              acc_val_next  = item.value;
              acc_wr_next   = 1'b1;
              acc_push_next = 1'b1;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (sp < SP_W'(2)) begin
              acc_status_next = ST_UNDER;
            end else if (item.opcode == OP_DIV) begin
              if (top_reg == '0) begin
                acc_status_next = ST_DIVZERO;
              end else begin
                acc_load      = 1'b0;
                div_req.start = 1'b1;
                state_next    = S_DIV;
              end
            end else begin
              acc_wr_next = 1'b1;
              if (item.opcode == OP_ADD) begin
                acc_val_next = left + top_reg;
              end else if (item.opcode == OP_SUB) begin
                acc_val_next = left - top_reg;
              end else begin
                acc_val_next = left * top_reg;
              end
            end
          end
          default: begin
            acc_status_next = ST_OK;
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          acc_load     = 1'b1;
          acc_val_next = div_rsp.quotient;
          acc_wr_next  = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          finish     = 1'b1;
          wr_en      = acc_wr;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Stack pointer and output valid; a new result takes over from a finished transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      res_valid <= 1'b0;
    end else begin
      if (finish) begin
        sp        <= item.last ? '0 : sp_after;
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Token, pending result, cached top and output payload.
  always_ff @(posedge clk) begin
    if (tok_valid && tok_ready) begin
      item <= tok;
    end
    if (acc_load) begin
      acc_val    <= acc_val_next;
      acc_status <= acc_status_next;
      acc_wr     <= acc_wr_next;
      acc_push   <= acc_push_next;
    end
    if (finish) begin
      top_reg       <= top_after;
      res.top_value <= top_after;
      res.depth     <= DEPTH_W'(sp_after);
      res.status    <= acc_status;
      res.done_res  <= item.last;
    end
  end

  // Checks on the controller and stack bookkeeping.
  `ASSERT_NEVER(a_sp_range, sp > SP_W'(STACK_DEPTH), "stack pointer beyond stack depth")
  `ASSERT_CLK(a_err_no_write, finish && (acc_status != ST_OK) |-> !wr_en, "error token wrote the stack")
  `ASSERT_CLK(a_last_clears, finish && item.last |=> sp == '0, "last token did not empty the stack")
  `ASSERT_CLK(a_div_done_state, div_rsp.done |-> state == S_DIV, "divider finished outside a divide")

endmodule

@@ src/rpn_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; used for the operand stack.
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/rpn_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg for the data width and the request and response structs.
module rpn_div (
  input  logic              clk,
  input  logic              rst,
  input  rpn_pkg::div_req_t req,
  output rpn_pkg::div_rsp_t rsp
);
  import rpn_pkg::*;

  logic              busy;
  logic              done;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  word_t             rem;
  word_t             quo;
  word_t             dvs;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign shifted = {rem, quo[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  // Control registers; done pulses for one cycle after the last step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == CNT_W'(DATA_W - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: operands are taken as magnitudes and the sign is restored at the end.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend[DATA_W-1] ? -req.dividend : req.dividend;
      dvs <= req.divisor[DATA_W-1] ? -req.divisor : req.divisor;
      neg <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? -quo : quo;

endmodule
